### rtl/fqs_pkg.sv
package fqs_pkg;

   // queue geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OP_W = 3;
   localparam int STAT_W = 2;
   localparam int POS_W = 5;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   // opcodes
   localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
   localparam logic [OP_W-1:0] OP_SEARCH  = 3'd2;
   localparam logic [OP_W-1:0] OP_PEEK    = 3'd3;
   localparam logic [OP_W-1:0] OP_DISPLAY = 3'd4;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic start;
      logic insert;
      logic underflow;
      logic head_out;
      logic pop;
      logic scan;
      logic search;
      logic drain;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic full;
      logic empty;
      logic out_free;
      logic scan_done;
   } stat_type;

   // ring index of base plus an offset below the depth
   function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
                                                 logic [CNT_W-1:0] offs);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(offs);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

### rtl/fqs_if.sv
// request channel
interface fqs_req_if import fqs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          opcode;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface

// response channel
interface fqs_rsp_if import fqs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] result_value;
   logic [POS_W-1:0]         position;
   logic                     last;

   modport source (output valid, output status, output result_value, output position,
                   output last, input ready);
   modport sink (input valid, input status, input result_value, input position,
                 input last, output ready);
endinterface

### rtl/fifo_queue_with_search.sv
// FIFO queue of signed 32-bit values with linear search.
//
// req_ch carries opcode and value; an item transfers when valid and ready are
// both high. Opcodes: insert, delete, search, peek, display; other codes are
// taken and dropped with no response. rsp_ch carries status,
// result_value, position and last; last marks the final response of an item.
// The block works on one item at a time: ready is high only when idle.
// Insert, delete, peek and any underflow give one response, which the state after
// IDLE writes into the output register once that register is free.
// Search and display read one stored entry per cycle, unless a result waits
// on a stalled output, from the single read port of the entry store. Search
// holds back one match so the last one can be marked.
// A stalled receiver holds the single output register; the scan waits when it
// needs that register and resumes without loss once the response transfers.
// Synchronous reset empties the queue (head, tail and count to zero) and
// drops any pending response; stored entries are never cleared.
module fifo_queue_with_search import fqs_pkg::*; (
   input logic     clock,
   input logic     reset,
   fqs_req_if.sink   req_ch,
   fqs_rsp_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   fqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // store, pointers and result register
   fqs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_ch.value),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_status   (rsp_ch.status),
      .rsp_value    (rsp_ch.result_value),
      .rsp_position (rsp_ch.position),
      .rsp_last     (rsp_ch.last)
   );

endmodule

### rtl/fqs_ctrl.sv
module fqs_ctrl import fqs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_opcode,
   output logic            req_ready,
   input  stat_type        stat,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_UNDER,
      S_HEAD,
      S_SCAN,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      search_ff, search_in;
   logic      pop_ff, pop_in;
   logic      take;

   assign req_ready = (state_ff == S_IDLE);
   assign take      = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      search_in = search_ff;
      pop_in    = pop_ff;
      cmd       = '0;
      cmd.pop    = pop_ff;
      cmd.search = search_ff;
      case (state_ff)
         S_IDLE: begin
            if (take && req_opcode <= OP_DISPLAY) begin
               cmd.start = 1'b1;
               search_in = (req_opcode == OP_SEARCH);
               pop_in    = (req_opcode == OP_DELETE);
               if (req_opcode == OP_INSERT) begin
                  state_in = S_INSERT;
               end else if (stat.empty) begin
                  state_in = S_UNDER;
               end else if (req_opcode == OP_DELETE || req_opcode == OP_PEEK) begin
                  state_in = S_HEAD;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_INSERT: begin
            if (stat.out_free) begin
               cmd.insert = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_UNDER: begin
            if (stat.out_free) begin
               cmd.underflow = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_HEAD: begin
            if (stat.out_free) begin
               cmd.head_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = search_ff ? S_DRAIN : S_IDLE;
            end
         end
         S_DRAIN: begin
            if (stat.out_free) begin
               cmd.drain = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and mode flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         search_ff <= 1'b0;
         pop_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         search_ff <= search_in;
         pop_ff    <= pop_in;
      end
   end

endmodule

### rtl/fqs_datapath.sv
module fqs_datapath import fqs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [DATA_W-1:0] req_value,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [POS_W-1:0]         rsp_position,
   output logic                     rsp_last
);

   logic [DATA_W-1:0] mem [DEPTH];

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic [CNT_W-1:0]  chk_pos_ff, chk_pos_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [DATA_W-1:0] pend_value_ff, pend_value_in;
   logic [CNT_W-1:0]  pend_pos_ff, pend_pos_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic              out_valid_ff, out_valid_in;
   logic [STAT_W-1:0] out_status_ff, out_status_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic              out_last_ff, out_last_in;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic              out_free;
   logic              match;
   logic              consume_ok;

   assign out_free       = !out_valid_ff || rsp_ready;
   assign match          = (rd_data_ff == key_ff);
   assign stat.full      = (count_ff == FULL_COUNT);
   assign stat.empty     = (count_ff == '0);
   assign stat.out_free  = out_free;
   assign stat.scan_done = !rd_valid_ff && (iss_ff == count_ff);

   // a scanned entry may retire unless it has to push a result into a busy slot
   always_comb begin
      if (cmd.search) begin
         consume_ok = !(match && pend_valid_ff) || out_free;
      end else begin
         consume_ok = out_free;
      end
   end

   // queue pointers, scan walk and result register
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      iss_in        = iss_ff;
      chk_pos_in    = chk_pos_ff;
      rd_valid_in   = rd_valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      pend_pos_in   = pend_pos_ff;
      key_in        = key_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      wr_en         = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_pos_in    = out_pos_ff;
      out_last_in   = out_last_ff;

      // accepted item: latch value and fetch the head entry
      if (cmd.start) begin
         rd_en         = 1'b1;
         rd_addr       = head_ff;
         iss_in        = CNT_W'(1);
         chk_pos_in    = CNT_W'(1);
         rd_valid_in   = 1'b1;
         key_in        = req_value;
         pend_valid_in = 1'b0;
      end

      // append at tail
      if (cmd.insert) begin
         out_valid_in  = 1'b1;
         out_status_in = stat.full ? ST_FULL : ST_OK;
         out_value_in  = '0;
         out_pos_in    = '0;
         out_last_in   = 1'b1;
         if (!stat.full) begin
            wr_en    = 1'b1;
            tail_in  = ring_add(tail_ff, CNT_W'(1));
            count_in = count_ff + CNT_W'(1);
         end
      end

      // operation on an empty queue
      if (cmd.underflow) begin
         out_valid_in  = 1'b1;
         out_status_in = ST_EMPTY;
         out_value_in  = '0;
         out_pos_in    = '0;
         out_last_in   = 1'b1;
      end

      // peek or delete the head
      if (cmd.head_out) begin
         out_valid_in  = 1'b1;
         out_status_in = ST_OK;
         out_value_in  = rd_data_ff;
         out_pos_in    = '0;
         out_last_in   = 1'b1;
         if (cmd.pop) begin
            head_in  = ring_add(head_ff, CNT_W'(1));
            count_in = count_ff - CNT_W'(1);
         end
      end

      // final search result: held match or not found
      if (cmd.drain) begin
         out_valid_in  = 1'b1;
         out_status_in = pend_valid_ff ? ST_OK : ST_NOT_FOUND;
         out_value_in  = pend_valid_ff ? pend_value_ff : '0;
         out_pos_in    = pend_valid_ff ? POS_W'(pend_pos_ff) : '0;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end

      // walk head to tail, one entry a cycle unless a result waits on a stalled output
      if (cmd.scan) begin
         if (rd_valid_ff && consume_ok) begin
            if (!cmd.search) begin
               out_valid_in  = 1'b1;
               out_status_in = ST_OK;
               out_value_in  = rd_data_ff;
               out_pos_in    = POS_W'(chk_pos_ff);
               out_last_in   = (chk_pos_ff == count_ff);
            end else if (match) begin
               if (pend_valid_ff) begin
                  out_valid_in  = 1'b1;
                  out_status_in = ST_OK;
                  out_value_in  = pend_value_ff;
                  out_pos_in    = POS_W'(pend_pos_ff);
                  out_last_in   = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_value_in = rd_data_ff;
               pend_pos_in   = chk_pos_ff;
            end
         end
         if (!rd_valid_ff || consume_ok) begin
            if (iss_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = ring_add(head_ff, iss_ff);
               iss_in      = iss_ff + CNT_W'(1);
               chk_pos_in  = iss_ff + CNT_W'(1);
               rd_valid_in = 1'b1;
            end else begin
               rd_valid_in = 1'b0;
            end
         end
      end
   end

   // entry store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= key_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         iss_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         iss_ff        <= iss_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_pos_ff    <= chk_pos_in;
      pend_value_ff <= pend_value_in;
      pend_pos_ff   <= pend_pos_in;
      key_ff        <= key_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_pos_ff    <= out_pos_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_value    = out_value_ff;
   assign rsp_position = out_pos_ff;
   assign rsp_last     = out_last_ff;

   // a stalled result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_value_ff)
         && $stable(out_last_ff))
      else $error("stalled result overwritten");

   // accepted insert into a non-full queue grows it by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert && !stat.full |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the queue");

   // empty or full queue has head and tail together
   a_ring_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_COUNT) |-> head_ff == tail_ff)
      else $error("ring pointers disagree with entry count");

   // a new item starts with no held match
   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !pend_valid_ff)
      else $error("held match survived a new item");

endmodule
